// ===== hdl/skt_pkg.sv =====
// Shared types and constants for the sorted key table.
// No dependencies; imported by skt_cell and sorted_key_table_core.
package skt_pkg;

    localparam int KEY_W   = 32;
    localparam int COUNT_W = 5;

    localparam logic signed [KEY_W-1:0] KEY_SENTINEL = 32'sh7FFF_FFFF;

    localparam logic [2:0] CMD_INSERT   = 3'd0;
    localparam logic [2:0] CMD_FIND     = 3'd1;
    localparam logic [2:0] CMD_DELETE   = 3'd2;
    localparam logic [2:0] CMD_READ_MIN = 3'd3;
    localparam logic [2:0] CMD_READ_MAX = 3'd4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef struct packed {
        logic                    do_insert;
        logic                    do_delete;
        logic signed [KEY_W-1:0] key;
    } cell_op_t;

endpackage

// ===== hdl/skt_cell.sv =====
// One compare-and-shift cell of the sorted key chain.
// Depends on skt_pkg for cell_op_t and KEY_W.
module skt_cell (
    input  logic                             clk,
    input  skt_pkg::cell_op_t                op,
    input  logic                             occupied,
    input  logic signed [skt_pkg::KEY_W-1:0] prev_key,
    input  logic                             prev_past,
    input  logic signed [skt_pkg::KEY_W-1:0] next_key,
    output logic signed [skt_pkg::KEY_W-1:0] key_q,
    output logic                             past,
    output logic                             hit
);
    import skt_pkg::*;

    logic signed [KEY_W-1:0] key_reg;
    logic signed [KEY_W-1:0] key_next;

    assign key_q = key_reg;
    assign past  = !occupied || !(key_reg < op.key);
    assign hit   = occupied && (key_reg == op.key) && !prev_past;

    always_comb
    begin
        key_next = key_reg;
        if (op.do_insert)
        begin
            if (prev_past)
                key_next = prev_key;
            else if (past)
                key_next = op.key;
        end
        else if (op.do_delete)
        begin
            if (past)
                key_next = next_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== hdl/sorted_key_table_core.sv =====
// Top level of the sorted key table: command decode, chain of cells, result register.
// Depends on skt_pkg and skt_cell.
//
// Usage:
//   Command channel: cmd_valid / cmd_stall carry command and key. A transaction
//   completes at a rising edge with cmd_valid high and cmd_stall low.
//   Response channel: rsp_valid / rsp_stall carry status, value and count, one
//   response per command, in command order.
//   Response: registered; it appears in the cycle after its command is taken.
//   Throughput: one command per cycle while cmd_stall is low; every cell compares
//   its key with the command key, and cells past it shift on insert or delete.
//   Stall: while a response is held by rsp_stall, cmd_stall is raised and the
//   response payload holds until taken.
//   Reset: rst_n clears the entry count and the response valid; cell contents
//   are meaningless until written and are never shown, since the count marks
//   the end of the list.
//   count reports the entry count after the command, modulo 32.
module sorted_key_table_core #(
    parameter int CAPACITY = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  logic [2:0]                       command,
    input  logic signed [skt_pkg::KEY_W-1:0] key,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output logic [1:0]                       status,
    output logic signed [skt_pkg::KEY_W-1:0] value,
    output logic [skt_pkg::COUNT_W-1:0]      count
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             rsp_valid_reg;
    status_t          status_reg, status_next;
    logic signed [KEY_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0]      rsp_count_reg;

    logic                    accept;
    logic                    found;
    logic                    is_full;
    logic                    is_empty;
    logic signed [KEY_W-1:0] largest;
    cell_op_t                op;

    logic signed [KEY_W-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0]     occ;
    logic [CAPACITY-1:0]     past;
    logic [CAPACITY-1:0]     hit;
    logic [CAPACITY-1:0]     last;

    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign found     = |hit;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [KEY_W-1:0] prev_key;
            logic                    prev_past;
            logic signed [KEY_W-1:0] next_key;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign prev_key  = '0;
                assign prev_past = 1'b0;
            end
            else
            begin : g_body
                assign prev_key  = cell_key[gi-1];
                assign prev_past = past[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign next_key = cell_key[gi];
                assign last[gi] = occ[gi];
            end
            else
            begin : g_inner
                assign next_key = cell_key[gi+1];
                assign last[gi] = occ[gi] && !occ[gi+1];
            end

            skt_cell u_cell (
                .clk       (clk),
                .op        (op),
                .occupied  (occ[gi]),
                .prev_key  (prev_key),
                .prev_past (prev_past),
                .next_key  (next_key),
                .key_q     (cell_key[gi]),
                .past      (past[gi]),
                .hit       (hit[gi])
            );
        end
    endgenerate

    always_comb
    begin
        largest = '0;
        for (int i = 0; i < CAPACITY; i++)
            largest = largest | (cell_key[i] & {KEY_W{last[i]}});
    end

    always_comb
    begin
        op.do_insert = 1'b0;
        op.do_delete = 1'b0;
        op.key       = key;
        count_next   = count_reg;
        status_next  = ST_OK;
        value_next   = key;
        unique case (command)
            CMD_INSERT:
            begin
                if (key == KEY_SENTINEL)
                    status_next = ST_MISSING;
                else if (is_full)
                    status_next = ST_FULL;
                else
                begin
                    op.do_insert = accept;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            CMD_FIND:
            begin
                if (!found)
                    status_next = ST_MISSING;
            end
            CMD_DELETE:
            begin
                if (found)
                begin
                    op.do_delete = accept;
                    count_next   = count_reg - CNT_W'(1);
                end
                else
                    status_next = ST_MISSING;
            end
            CMD_READ_MIN, CMD_READ_MAX:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                    value_next  = '0;
                end
                else if (command == CMD_READ_MIN)
                    value_next = cell_key[0];
                else
                    value_next = largest;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            value_reg     <= value_next;
            rsp_count_reg <= COUNT_W'(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status    = status_reg;
    assign value     = value_reg;
    assign count     = rsp_count_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_INSERT && !is_full && key != KEY_SENTINEL)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

    a_find_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_FIND) |=> (count_reg == $past(count_reg)))
        else $error("find changed the entry count");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid_reg)
        else $error("command stalled with no pending response");

    a_hit_single: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("more than one cell claims the first match");
`endif

endmodule
